@@ src/rsc_pkg.sv @@
// ----------------------------------------------------------------------------
// rsc_pkg
// shared types and codes of the refcounted slot cache
// ----------------------------------------------------------------------------
package rsc_pkg;

   localparam int CSR_W = 5;

   typedef enum logic [2:0] {
      ST_OK             = 3'd0,
      ST_OUT_OF_SLOTS   = 3'd1,
      ST_NO_REFERENCES  = 3'd2,
      ST_INVALID_SLOT   = 3'd3,
      ST_COUNT_OVERFLOW = 3'd4
   } status_type;

   typedef enum logic {
      MODE_LOCK    = 1'b0,
      MODE_RELEASE = 1'b1
   } mode_type;

   typedef struct packed {
      mode_type    mode;
      logic [15:0] leaf_index;
      logic [3:0]  slot_index;
   } req_type;

   typedef struct packed {
      logic [3:0] slot;
      logic       refill_needed;
      status_type status;
   } rsp_type;

endpackage

@@ src/rsc_cell.sv @@
// ----------------------------------------------------------------------------
// rsc_cell
// one cache slot: holds tag, tag valid and count, updates the passing search record
// ----------------------------------------------------------------------------
module rsc_cell #(
   parameter int  INDEX       = 0,
   parameter int  TAG_BITS    = 16,
   parameter int  COUNT_BITS  = 8,
   parameter int  SLOT_W      = 4,
   parameter type rec_type    = logic,
   parameter type commit_type = logic
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     shift,
   input  logic [rsc_pkg::CSR_W-1:0] slots_in_use,
   input  rec_type                  rec_in,
   output rec_type                  rec_out,
   input  commit_type               commit
);
   import rsc_pkg::*;

   logic [TAG_BITS-1:0]   tag_ff;
   logic                  valid_ff;
   logic [COUNT_BITS-1:0] count_ff;
   rec_type               rec_ff;
   rec_type               rec_in_upd;
   logic                  enabled;
   logic                  selected;

   assign enabled  = 32'(slots_in_use) > INDEX;
   assign selected = commit.en && (commit.slot == SLOT_W'(INDEX));
   assign rec_out  = rec_ff;

   // search step for this slot
   always_comb begin
      rec_in_upd = rec_in;
      if (rec_in.active && enabled) begin
         if (rec_in.mode == MODE_LOCK) begin
            if (!rec_in.hit && valid_ff && (tag_ff == rec_in.tag)) begin
               rec_in_upd.hit       = 1'b1;
               rec_in_upd.hit_slot  = SLOT_W'(INDEX);
               rec_in_upd.hit_count = count_ff;
            end
            if (!rec_in.free && (count_ff == '0)) begin
               rec_in_upd.free      = 1'b1;
               rec_in_upd.free_slot = SLOT_W'(INDEX);
            end
         end else if (32'(rec_in.slot_index) == INDEX) begin
            rec_in_upd.rel_ok    = 1'b1;
            rec_in_upd.rel_count = count_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff <= '0;
      end else if (shift) begin
         rec_ff <= rec_in_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         count_ff <= '0;
      end else if (selected) begin
         if (commit.write_tag) begin
            valid_ff <= 1'b1;
         end
         if (commit.inc) begin
            count_ff <= count_ff + 1'b1;
         end else if (commit.dec) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (selected && commit.write_tag) begin
         tag_ff <= commit.tag;
      end
   end

endmodule

@@ src/refcounted_slot_cache.sv @@
// ----------------------------------------------------------------------------
// refcounted_slot_cache
// reference counted tag cache slot allocator built as a chain of slot cells
// ----------------------------------------------------------------------------
// a request is registered in head_ff and its search record walks the cell chain one
// slot per cycle while no stalled response holds it; the response is then registered
// in the output register; a new request is taken only after the record leaves the tail
// reset: all tags invalid, all counts zero, slots_in_use 16; no clearing pass
// a stalled response holds the record at the chain tail and freezes the chain
// ----------------------------------------------------------------------------
module refcounted_slot_cache #(
   parameter int MAX_SLOTS  = 16,
   parameter int TAG_BITS   = 16,
   parameter int COUNT_BITS = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  rsc_pkg::req_type          req_payload,
   // response channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsc_pkg::rsp_type          rsp_payload,
   // slot count register
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [rsc_pkg::CSR_W-1:0] csr_data
);
   import rsc_pkg::*;

   localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

   // search record carried down the chain
   typedef struct packed {
      logic                  active;
      mode_type              mode;
      logic [TAG_BITS-1:0]   tag;
      logic [3:0]            slot_index;
      logic                  hit;
      logic [SLOT_W-1:0]     hit_slot;
      logic [COUNT_BITS-1:0] hit_count;
      logic                  free;
      logic [SLOT_W-1:0]     free_slot;
      logic                  rel_ok;
      logic [COUNT_BITS-1:0] rel_count;
   } rec_type;

   // state update broadcast to all cells
   typedef struct packed {
      logic                en;
      logic [SLOT_W-1:0]   slot;
      logic                write_tag;
      logic [TAG_BITS-1:0] tag;
      logic                inc;
      logic                dec;
   } commit_type;

   logic [CSR_W-1:0]     slots_in_use_ff;
   logic                 busy_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;
   rec_type              head_ff;
   rec_type              head_in;
   rec_type              chain [MAX_SLOTS+1];
   rec_type              tail;
   logic [MAX_SLOTS-1:0] active_vec;
   logic                 req_accept;
   logic                 hold;
   logic                 shift;
   logic                 finish;
   commit_type           commit;
   rsp_type              rsp_in;

   assign req_stall   = busy_ff;
   assign req_accept  = req_valid && !busy_ff;
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // the record waits at the tail while the output register is full and stalled
   assign tail   = chain[MAX_SLOTS];
   assign hold   = tail.active && rsp_valid_ff && rsp_stall;
   assign shift  = !hold;
   assign finish = tail.active && shift;

   // slot count register
   always_ff @(posedge clock) begin
      if (reset) begin
         slots_in_use_ff <= CSR_W'(16);
      end else if (csr_valid && csr_ready) begin
         slots_in_use_ff <= csr_data;
      end
   end

   // fresh search record built from the request
   always_comb begin
      head_in            = '0;
      head_in.active     = 1'b1;
      head_in.mode       = req_payload.mode;
      head_in.tag        = TAG_BITS'(req_payload.leaf_index);
      head_in.slot_index = req_payload.slot_index;
   end

   // request register feeding cell 0
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
      end else if (req_accept) begin
         head_ff <= head_in;
      end else if (shift) begin
         head_ff.active <= 1'b0;
      end
   end

   assign chain[0] = head_ff;

   // one cell per slot, the record moves one cell per cycle while the chain is not held
   for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
      rsc_cell #(
         .INDEX       (i),
         .TAG_BITS    (TAG_BITS),
         .COUNT_BITS  (COUNT_BITS),
         .SLOT_W      (SLOT_W),
         .rec_type    (rec_type),
         .commit_type (commit_type)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .shift        (shift),
         .slots_in_use (slots_in_use_ff),
         .rec_in       (chain[i]),
         .rec_out      (chain[i+1]),
         .commit       (commit)
      );
      assign active_vec[i] = chain[i+1].active;
   end

   // decision at the tail: response fields and the state update
   always_comb begin
      commit           = '0;
      commit.tag       = tail.tag;
      rsp_in.slot          = '0;
      rsp_in.refill_needed = 1'b0;
      rsp_in.status        = ST_OK;
      if (tail.mode == MODE_LOCK) begin
         if (tail.hit) begin
            // tag already present, only the count moves
            commit.slot = tail.hit_slot;
            rsp_in.slot = 4'(tail.hit_slot);
            if (tail.hit_count == '1) begin
               rsp_in.status = ST_COUNT_OVERFLOW;
            end else begin
               commit.en  = finish;
               commit.inc = 1'b1;
            end
         end else if (tail.free) begin
            // take over an unreferenced slot and retag it
            commit.slot          = tail.free_slot;
            commit.en            = finish;
            commit.inc           = 1'b1;
            commit.write_tag     = 1'b1;
            rsp_in.slot          = 4'(tail.free_slot);
            rsp_in.refill_needed = 1'b1;
         end else begin
            rsp_in.status = ST_OUT_OF_SLOTS;
         end
      end else begin
         rsp_in.slot = tail.slot_index;
         commit.slot = SLOT_W'(tail.slot_index);
         if (!tail.rel_ok) begin
            rsp_in.status = ST_INVALID_SLOT;
         end else if (tail.rel_count == '0) begin
            rsp_in.status = ST_NO_REFERENCES;
         end else begin
            commit.en  = finish;
            commit.dec = 1'b1;
         end
      end
   end

   // busy from accept until the record leaves the tail
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (req_accept) begin
         busy_ff <= 1'b1;
      end else if (finish) begin
         busy_ff <= 1'b0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_ff <= rsp_in;
      end
   end

   // at most one search record is in the chain
   a_one_record: assert property (@(posedge clock) disable iff (reset)
      $countones(active_vec) <= 1)
      else $error("more than one search record in the cell chain");

   // state changes only for a transaction in flight
   a_commit_busy: assert property (@(posedge clock) disable iff (reset)
      commit.en |-> busy_ff)
      else $error("slot update without a transaction in flight");

   // a new response always comes from a finished transaction
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(busy_ff))
      else $error("response raised without a transaction in flight");

   // an accepted request blocks further requests
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> busy_ff)
      else $error("request accepted but block not busy");

endmodule
